// ===== rtl/linear_probe_hash_table_assert.svh =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_assert.svh
// assertion macros used by the hash table checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants, codes and control structs of the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TBL_SIZE = 16;
  localparam int IDX_W    = $clog2(TBL_SIZE);
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new word, read its home slot
    logic step;    // move to the next slot
    logic finish;  // register the result, commit any write
  } lpht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;       // probe has reached its outcome
    logic out_free;  // output register can take a result this cycle
  } lpht_sts_t;

endpackage

// ===== rtl/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// probe sequencer: idle, then one slot per cycle until the outcome is known
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PROBE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.step   = (state_r == S_PROBE) && !sts.hit;
  assign cmd.finish = (state_r == S_PROBE) && sts.hit && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (cmd.finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lpht_datapath.sv =====
// ----------------------------------------------------------------------------
// lpht_datapath
// key store with per-slot valid bits, probe pointer, outcome logic and
// output register
// ----------------------------------------------------------------------------
module lpht_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lpht_pkg::lpht_cmd_t             cmd,
  output lpht_pkg::lpht_sts_t             sts,
  input  logic                            in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]   out_status,
  output logic [lpht_pkg::SLOT_W-1:0]     out_slot,
  output logic                            out_collided
);
  import lpht_pkg::*;

  logic [KEY_W-1:0]    key_mem [TBL_SIZE];
  logic [TBL_SIZE-1:0] valid_r;

  logic [KEY_W-1:0]    key_r;
  logic                op_r;
  logic [IDX_W-1:0]    pos_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                coll_r;
  logic [KEY_W-1:0]    rd_q;
  logic                rd_vld_q;

  logic [IDX_W-1:0]    home;
  logic [IDX_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    rd_addr;
  logic                last;
  logic                empty;
  logic                match;
  logic                coll_now;
  logic                wr_en;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_coll;
  logic                res_hit;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_coll_r;

  assign home    = IDX_W'(in_key % TBL_SIZE);
  assign pos_inc = (pos_r == IDX_W'(TBL_SIZE - 1)) ? '0 : pos_r + 1'b1;
  assign last    = (cnt_r == IDX_W'(TBL_SIZE - 1));
  assign empty   = !rd_vld_q;
  assign match   = rd_vld_q && (rd_q == key_r);

  // home slot data is in the read register on the first probe cycle
  assign coll_now = (cnt_r == '0) ? (rd_vld_q && (rd_q != key_r)) : coll_r;

  always_comb begin
    if (cmd.load) begin
      rd_addr = home;
    end else if (cmd.step) begin
      rd_addr = pos_inc;
    end else begin
      rd_addr = pos_r;
    end
  end

  always_comb begin
    res_hit    = 1'b0;
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    res_coll   = coll_now;
    if (key_r == '0) begin
      res_hit    = 1'b1;
      res_status = ST_INVALID;
      res_coll   = 1'b0;
    end else if (op_r == OP_INSERT) begin
      if (empty) begin
        res_hit    = 1'b1;
        res_status = ST_INSERTED;
        res_slot   = SLOT_W'(pos_r);
      end else if (last) begin
        res_hit    = 1'b1;
        res_status = ST_FULL;
      end
    end else begin
      if (match) begin
        res_hit    = 1'b1;
        res_status = ST_FOUND;
        res_slot   = SLOT_W'(pos_r);
      end else if (empty || last) begin
        res_hit    = 1'b1;
        res_status = ST_NOT_FOUND;
      end
    end
  end

  assign wr_en = cmd.finish && (res_status == ST_INSERTED);

  assign sts.hit      = res_hit;
  assign sts.out_free = !out_valid_r || out_ready;

  // key store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) key_mem[pos_r] <= key_r;
    rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) valid_r[pos_r] <= 1'b1;
      rd_vld_q <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      op_r   <= in_opcode;
      pos_r  <= home;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      pos_r  <= pos_inc;
      cnt_r  <= cnt_r + 1'b1;
      coll_r <= coll_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_coll_r   <= res_coll;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_collided = out_coll_r;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressing hash set of 16 nonzero 32-bit keys with linear probing
// ----------------------------------------------------------------------------
// One word is taken at a time. The cycle it is accepted reads the home slot
// (key modulo 16); after that one slot is examined per cycle through the
// single read port of the key store, 1 to 16 slots in all. When the outcome
// is known the result is registered and the block returns to idle, where the
// next word can be accepted. Key zero is rejected on its first probe. The
// result sits in an output register, so a held result does not stop the next
// word from being accepted; the probe only stalls on its outcome if the
// previous result has still not been taken. Reset empties the table at once
// through per-slot valid bits: there is no clearing pass.
module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]   out_status,
  output logic [lpht_pkg::SLOT_W-1:0]     out_slot,
  output logic                            out_collided
);
  import lpht_pkg::*;

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_opcode),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_collided (out_collided)
  );

endmodule

// ===== rtl/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// lpht_checker
// port-level checks of the hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_opcode,
  input logic [lpht_pkg::KEY_W-1:0]      in_key,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lpht_pkg::STATUS_W-1:0]   out_status,
  input logic [lpht_pkg::SLOT_W-1:0]     out_slot,
  input logic                            out_collided
);
  import lpht_pkg::*;

  logic                                  in_wait;
  logic [KEY_W:0]                        in_word;
  logic                                  out_held;
  logic [STATUS_W+SLOT_W:0]              out_word;
  logic                                  no_slot_res;
  logic                                  rejected;

  assign in_wait     = in_valid && !in_ready;
  assign in_word     = {in_opcode, in_key};
  assign out_held    = out_valid && !out_ready;
  assign out_word    = {out_status, out_slot, out_collided};
  assign no_slot_res = out_valid && (out_status == ST_NOT_FOUND ||
                                     out_status == ST_FULL ||
                                     out_status == ST_INVALID);
  assign rejected    = out_valid && (out_status == ST_INVALID);

  // a waiting input word stays put
  `LPHT_ASSERT_NXT(a_in_hold, in_wait, in_valid && $stable(in_word), "input word changed")

  // a held result keeps its value
  `LPHT_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_word), "result changed")

  // one word in flight: busy straight after an accept
  `LPHT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "back to back accept")

  // misses, full and rejects report slot zero
  `LPHT_ASSERT_NOW(a_slot_zero, no_slot_res, out_slot == '0, "nonzero slot on a miss")

  // a rejected key never reports a collision
  `LPHT_ASSERT_NOW(a_invalid_no_coll, rejected, !out_collided, "collision on zero key")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_opcode    (in_opcode),
  .in_key       (in_key),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_slot     (out_slot),
  .out_collided (out_collided)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the linear probe hash table
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the 16-slot key store and works out the
// status, slot and collision flag of every word the block accepts. Results
// are compared field by field, in order. A short directed run covers the
// reserved key, wraparound, clustering and duplicate inserts. A random run
// then fills the store gradually, so that most probes run through clusters,
// and ends on a full table where inserts are refused and misses scan every
// slot. Both handshakes idle at random, with calm stretches in between.
module tb_top;
  import lpht_pkg::*;

  localparam int RAND_WORDS  = 1230;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                collided;
  } probe_result_t;

  class probe_table_scoreboard;
    logic [KEY_W-1:0] slots [TBL_SIZE];
    probe_result_t    pending_results [$];
    int               errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (slots[i]) if (slots[i] != '0) n++;
      return n;
    endfunction

    // a key held somewhere in the store; only called with at least one slot used
    function logic [KEY_W-1:0] stored_key();
      int idx;
      idx = $urandom_range(0, TBL_SIZE - 1);
      while (slots[idx] == '0) idx = (idx + 1) % TBL_SIZE;
      return slots[idx];
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // probe the local store the way the block does and queue the outcome
    function void note_word(logic op, logic [KEY_W-1:0] key);
      probe_result_t res;
      int            home;
      int            pos;
      int            tries;
      bit            done;
      res     = '0;
      res.key = key;
      done    = 1'b0;
      if (key == '0) begin
        res.status = ST_INVALID;
      end else begin
        home         = int'(key % TBL_SIZE);
        res.collided = (slots[home] != '0) && (slots[home] != key);
        pos          = home;
        if (op == OP_INSERT) begin
          res.status = ST_FULL;
          for (tries = 0; tries < TBL_SIZE && !done; tries++) begin
            if (slots[pos] == '0) begin
              slots[pos] = key;
              res.status = ST_INSERTED;
              res.slot   = SLOT_W'(pos);
              done       = 1'b1;
            end else begin
              pos = (pos + 1) % TBL_SIZE;
            end
          end
        end else begin
          res.status = ST_NOT_FOUND;
          for (tries = 0; tries < TBL_SIZE && !done; tries++) begin
            if (slots[pos] == key) begin
              res.status = ST_FOUND;
              res.slot   = SLOT_W'(pos);
              done       = 1'b1;
            end else if (slots[pos] == '0) begin
              done = 1'b1;
            end else begin
              pos = (pos + 1) % TBL_SIZE;
            end
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic collided);
      probe_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d "
                 , $time, status, slot, "collided %0d", collided);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (status !== exp.status) begin
          $display("%0t: key %h status: expected %0d actual %0d",
                   $time, exp.key, exp.status, status);
          errors++;
        end
        if (slot !== exp.slot) begin
          $display("%0t: key %h slot: expected %0d actual %0d",
                   $time, exp.key, exp.slot, slot);
          errors++;
        end
        if (collided !== exp.collided) begin
          $display("%0t: key %h collided: expected %0d actual %0d",
                   $time, exp.key, exp.collided, collided);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_opcode    = OP_INSERT;
  logic [KEY_W-1:0]    in_key       = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_collided;

  probe_table_scoreboard sb;
  int                    tx_calm     = 0;
  int                    rx_calm     = 0;
  int                    cycle_count = 0;

  linear_probe_hash_table dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_collided (out_collided)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // random wait per word, with occasional calm stretches of back-to-back words
  function automatic int idle_cycles(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    int gap;
    gap = idle_cycles(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= op;
    in_key    <= key;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_word(op, key);
  endtask

  function automatic logic [KEY_W-1:0] extreme_key();
    logic [KEY_W-1:0] nib;
    nib = KEY_W'($urandom_range(0, TBL_SIZE - 1));
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h8000_0000 | nib;
      2:       return 32'hFFFF_FFF0 | nib;
      default: return nib;
    endcase
  endfunction

  // the store fills step by step and is full for the last fifth of the run
  function automatic void pick_word(input int idx, output logic op,
                                    output logic [KEY_W-1:0] key);
    int               used;
    int               goal;
    int               pick;
    logic [KEY_W-1:0] noise;
    logic [KEY_W-1:0] held;
    used  = sb.used_slots();
    goal  = (idx * 20) / RAND_WORDS;
    pick  = $urandom_range(0, 99);
    noise = $urandom();
    if (used > 0)
      held = sb.stored_key();
    else
      held = '0;
    if ($urandom_range(0, 99) < 3) begin
      op  = logic'($urandom_range(0, 1));
      key = '0;
    end else if (used < goal || (used == TBL_SIZE && $urandom_range(0, 4) == 0)) begin
      op = OP_INSERT;
      if (used > 0 && pick < 30)
        key = {noise[KEY_W-1:4], held[3:0]};
      else if (used > 0 && pick < 45)
        key = held;
      else if (pick < 60)
        key = {noise[KEY_W-1:4], 3'b111, noise[0]};
      else if (pick < 70)
        key = extreme_key();
      else
        key = noise;
    end else begin
      op = OP_SEARCH;
      if (used > 0 && pick < 55)
        key = held;
      else if (used > 0 && pick < 75)
        key = {noise[KEY_W-1:4], held[3:0]};
      else if (pick < 85)
        key = extreme_key();
      else
        key = noise;
    end
  endfunction

  task automatic run_directed();
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_SEARCH, 32'h0000_0000);
    send_word(OP_SEARCH, 32'h0000_0005);
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_001F);  // home 15 taken, wraps to slot 0
    send_word(OP_INSERT, 32'h0000_0010);
    send_word(OP_SEARCH, 32'h0000_0010);
    send_word(OP_SEARCH, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 32'h0000_002F);  // miss after walking the cluster
    send_word(OP_INSERT, 32'hFFFF_FFFF);  // duplicate lands further along
    send_word(OP_SEARCH, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h8000_0003);
    send_word(OP_SEARCH, 32'h8000_0003);
    send_word(OP_INSERT, 32'h1234_5678);
    send_word(OP_SEARCH, 32'h0000_0008);
    send_word(OP_SEARCH, 32'h0000_0001);
    send_word(OP_INSERT, 32'h7FFF_FFFE);
    send_word(OP_SEARCH, 32'h5555_AAAA);
  endtask

  initial begin
    logic             op;
    logic [KEY_W-1:0] key;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int i = 0; i < RAND_WORDS; i++) begin
      pick_word(i, op, key);
      send_word(op, key);
    end
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_cycles(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_result(out_status, out_slot, out_collided);
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_datapath.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
verif/tb_top.sv
